[design/tept_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tept_pkg
// Types, constants and helper functions shared by the entry table modules.
// ----------------------------------------------------------------------------
package tept_pkg;

  localparam int CAPACITY    = 16;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int MAX_RESULTS = 16;
  localparam int STAMP_W     = 34;
  localparam int QDEPTH      = 2;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_COUNT     = 3'd1,
    OP_EARLIEST  = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_OWNER = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_LIST      = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] owner_id;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  tally;
    logic [15:0] entry_owner;
    logic [13:0] entry_year;
    logic [3:0]  entry_month;
    logic [4:0]  entry_day;
    logic [4:0]  entry_hour;
    logic [5:0]  entry_minute;
    logic        last;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t                  op;
    logic                 bad;
    logic [15:0]          owner;
    logic [STAMP_W-1:0]   stamp;
  } cmd_t;

  // Days in a month, month 1 to 12, leap handled by the caller.
  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] len;
    unique case (mo)
      4'd2:                          len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:       len = 5'd30;
      default:                       len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[design/timestamped_entry_priority_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_entry_priority_table_top
// Table of owner/date-time entries with earliest-first access.
//
//   Port group   Direction  Handshake           Payload
//   in_*         input      in_valid/in_stall   in_item_t
//   out_*        output     out_valid/out_stall out_item_t
//   cfg_*        input      cfg_we              capacity limit (5 bits)
//
// Every operation walks all 16 slots, one slot a cycle; list all repeats the
// walk per result. Synchronous active-low reset empties the table and sets
// the limit to 16. A two-entry command queue keeps input transfers flowing
// while a result waits on out_stall.
// ----------------------------------------------------------------------------
module timestamped_entry_priority_table_top import tept_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_data
);

  logic [4:0] limit_r;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd_data;

  // Capacity limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 5'd16;
    else if (cfg_we) limit_r <= cfg_data;
  end

  tept_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd_data
  );

  tept_back u_back (
    .clk, .rst_n, .cfg_limit(limit_r), .cmd_valid, .cmd_take, .cmd_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

[design/tept_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tept_front
// Accepts operations, checks date and time, and queues classified commands.
// ----------------------------------------------------------------------------
module tept_front import tept_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd_data
);

  // Leap year test: the year is at most 14 bits, so year / 100 comes from a
  // reciprocal multiplication, exact over that range. Divisibility by 400 is
  // divisibility by 100 with a quotient that is a multiple of four.
  logic [13:0] yr;
  logic [26:0] prod;
  logic [7:0]  q100;
  logic        div100;
  logic        leap, date_ok, time_ok;
  logic [4:0]  len;
  cmd_t        cmd;

  always_comb begin
    yr     = in_data.year;
    prod   = 27'(yr) * 27'(13'd5243);
    q100   = prod[26:19];
    div100 = ((15'(q100) * 15'd100) == {1'b0, yr});
    leap   = ((yr[1:0] == 2'd0) && !div100) || (div100 && (q100[1:0] == 2'd0));
    len  = month_len(in_data.month) +
           5'((in_data.month == 4'd2) && leap);
    date_ok = (yr != 14'd0) && (in_data.month >= 4'd1) && (in_data.month <= 4'd12) &&
              (in_data.day != 5'd0) && (in_data.day <= len);
    time_ok = (in_data.hour <= 5'd23) && (in_data.minute <= 6'd59);
    cmd.op    = op_t'(in_data.kind);
    cmd.owner = in_data.owner_id;
    cmd.stamp = {in_data.year, in_data.month, in_data.day, in_data.hour, in_data.minute};
    cmd.bad   = (cmd.op == OP_INSERT) ? !(date_ok && time_ok) :
                (cmd.op == OP_COUNT)  ? !date_ok : 1'b0;
  end

  // Two-entry command queue.
  cmd_t       q_r [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;

  assign in_stall  = (cnt_r == 2'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd_data  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd;
  end

endmodule

[design/tept_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tept_back
// Holds the slots and carries out commands, one slot visited per cycle.
// ----------------------------------------------------------------------------
module tept_back import tept_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  cfg_limit,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  cmd_t        cmd_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // Slot storage: used bits reset, payload undefined until written.
  logic [CAPACITY-1:0] used_r;
  logic [15:0]         owner_r [CAPACITY];
  logic [STAMP_W-1:0]  stamp_r [CAPACITY];
  logic [CNT_W-1:0]    count_r;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [SLOT_W:0]     idx_r;
  logic [CAPACITY-1:0] done_r;
  logic                have_r;
  logic [SLOT_W-1:0]   best_r;
  logic                free_r;
  logic [SLOT_W-1:0]   free_idx_r;
  logic [CNT_W-1:0]    tally_r;
  logic [4:0]          emitted_r;
  logic [4:0]          total_r;
  out_item_t           out_r;
  logic                out_v_r;

  logic [SLOT_W-1:0]   i;
  logic                live, better, out_free, more;
  out_item_t           res;

  assign i        = idx_r[SLOT_W-1:0];
  assign live     = used_r[i] && !done_r[i];
  assign better   = live && (!have_r || (stamp_r[i] < stamp_r[best_r]));
  assign out_free = !out_v_r || !out_stall;
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign more      = (cmd_r.op == OP_LIST) && have_r && !res.last;

  // Result assembled at the end of a scan.
  always_comb begin
    res = '0;
    res.last = 1'b1;
    unique case (cmd_r.op)
      OP_INSERT: begin
        if (cmd_r.bad) res.status = ST_INVALID;
        else if (count_r >= CNT_W'(cfg_limit) || !free_r) res.status = ST_FULL;
      end
      OP_COUNT: begin
        if (cmd_r.bad) res.status = ST_INVALID;
        else res.tally = 5'(tally_r);
      end
      OP_EARLIEST, OP_DEL_FIRST, OP_LIST: begin
        if (!have_r) res.status = ST_EMPTY;
        else begin
          res.tally        = 5'(cmd_r.op == OP_DEL_FIRST);
          res.entry_owner  = owner_r[best_r];
          {res.entry_year, res.entry_month, res.entry_day, res.entry_hour,
           res.entry_minute} = stamp_r[best_r];
          if (cmd_r.op == OP_LIST)
            res.last = (emitted_r + 5'd1 == total_r) || (emitted_r == 5'(MAX_RESULTS - 1));
        end
      end
      OP_DEL_OWNER, OP_CLEAR: res.tally = 5'(tally_r);
      default: ;
    endcase
  end

  // Sequencer: scan all slots, then finish the command and emit its result; a list rescans for each further result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      count_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && !out_stall && state_r != S_DONE) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r     <= cmd_data;
            idx_r     <= '0;
            done_r    <= '0;
            have_r    <= 1'b0;
            free_r    <= 1'b0;
            tally_r   <= '0;
            emitted_r <= '0;
            total_r   <= 5'(count_r > CNT_W'(MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : count_r);
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (better) begin
            have_r <= 1'b1;
            best_r <= i;
          end
          if (!used_r[i] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= i;
          end
          unique case (cmd_r.op)
            OP_COUNT:
              if (used_r[i] && stamp_r[i][STAMP_W-1:11] == cmd_r.stamp[STAMP_W-1:11])
                tally_r <= tally_r + 1'b1;
            OP_DEL_OWNER:
              if (used_r[i] && owner_r[i] == cmd_r.owner) begin
                tally_r   <= tally_r + 1'b1;
                used_r[i] <= 1'b0;
                count_r   <= count_r - 1'b1;
              end
            OP_CLEAR:
              if (used_r[i]) begin
                tally_r   <= tally_r + 1'b1;
                used_r[i] <= 1'b0;
              end
            default: ;
          endcase
          if (idx_r == (SLOT_W+1)'(CAPACITY - 1)) state_r <= S_DONE;
          idx_r <= idx_r + 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            out_r   <= res;
            out_v_r <= 1'b1;
            state_r <= more ? S_SCAN : S_IDLE;
            unique case (cmd_r.op)
              OP_INSERT:
                if (res.status == ST_OK) begin
                  used_r[free_idx_r] <= 1'b1;
                  count_r <= count_r + 1'b1;
                end
              OP_DEL_FIRST:
                if (have_r) begin
                  used_r[best_r] <= 1'b0;
                  count_r <= count_r - 1'b1;
                end
              OP_CLEAR: count_r <= '0;
              OP_LIST:
                if (more) begin
                  done_r[best_r] <= 1'b1;
                  emitted_r      <= emitted_r + 5'd1;
                  have_r         <= 1'b0;
                  idx_r          <= '0;
                end
              default: ;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Slot payload write on a successful insert.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free && cmd_r.op == OP_INSERT && res.status == ST_OK) begin
      owner_r[free_idx_r] <= cmd_r.owner;
      stamp_r[free_idx_r] <= cmd_r.stamp;
    end
  end

endmodule
